>>> sv/expansion_scale_zero_elim_defines.svh
// assertion macros shared by the expansion scaler rtl
`ifndef EXPANSION_SCALE_ZERO_ELIM_DEFINES_SVH
`define EXPANSION_SCALE_ZERO_ELIM_DEFINES_SVH

// same-cycle implication
`define ESZE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESZE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/esze_pkg.sv
// types, constants and microcode shared by the expansion scaler
package esze_pkg;

	localparam int PC_W = 6;

	localparam logic [63:0] SPLITTER = 64'h41A0_0000_0200_0000;
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

	localparam logic [PC_W-1:0] PC_START = 6'd0;
	localparam logic [PC_W-1:0] PC_PROD = 6'd4;

	typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL} fop_t;

	typedef enum logic [2:0] {
		U_ADD, U_SUB, U_MUL, U_MOV, U_BRANCH, U_EMIT, U_FINAL, U_END
	} uop_t;

	typedef enum logic [3:0] {
		RG_K, RG_COMP, RG_SV, RG_SH, RG_SL, RG_RS, RG_P1, RG_AHI, RG_ALO, RG_S, RG_T0, RG_T1
	} reg_t;

	typedef struct packed {
		uop_t op;
		reg_t dst;
		reg_t a;
		reg_t b;
		logic [PC_W-1:0] nxt;
	} uinst_t;

	typedef struct packed {
		logic start;
		fop_t op;
	} fpu_req_t;

	typedef struct packed {
		logic vld;
		logic [63:0] bits;
		logic eor;
		logic eoe;
	} push_t;

	function automatic uinst_t mk(input uop_t op, input reg_t dst, input reg_t a,
		input reg_t b, input logic [PC_W-1:0] nxt);
		uinst_t u;
		u.op = op;
		u.dst = dst;
		u.a = a;
		u.b = b;
		u.nxt = nxt;
		return u;
	endfunction

	function automatic uinst_t ucode(input logic [PC_W-1:0] pc);
		uinst_t u;
		unique case (pc)
			// split of the scale factor
			6'd0: u = mk(U_MUL, RG_T0, RG_K, RG_SV, 6'd1);
			6'd1: u = mk(U_SUB, RG_T1, RG_T0, RG_SV, 6'd2);
			6'd2: u = mk(U_SUB, RG_SH, RG_T0, RG_T1, 6'd3);
			6'd3: u = mk(U_SUB, RG_SL, RG_SV, RG_SH, 6'd4);
			// exact product
			6'd4: u = mk(U_MUL, RG_P1, RG_COMP, RG_SV, 6'd5);
			6'd5: u = mk(U_MUL, RG_T0, RG_K, RG_COMP, 6'd6);
			6'd6: u = mk(U_SUB, RG_T1, RG_T0, RG_COMP, 6'd7);
			6'd7: u = mk(U_SUB, RG_AHI, RG_T0, RG_T1, 6'd8);
			6'd8: u = mk(U_SUB, RG_ALO, RG_COMP, RG_AHI, 6'd9);
			6'd9: u = mk(U_MUL, RG_T0, RG_AHI, RG_SH, 6'd10);
			6'd10: u = mk(U_SUB, RG_T1, RG_P1, RG_T0, 6'd11);
			6'd11: u = mk(U_MUL, RG_T0, RG_ALO, RG_SH, 6'd12);
			6'd12: u = mk(U_SUB, RG_T1, RG_T1, RG_T0, 6'd13);
			6'd13: u = mk(U_MUL, RG_T0, RG_AHI, RG_SL, 6'd14);
			6'd14: u = mk(U_SUB, RG_T1, RG_T1, RG_T0, 6'd15);
			6'd15: u = mk(U_MUL, RG_T0, RG_ALO, RG_SL, 6'd16);
			6'd16: u = mk(U_SUB, RG_T1, RG_T0, RG_T1, 6'd17);
			6'd17: u = mk(U_BRANCH, RG_K, RG_K, RG_K, 6'd20);
			// first component
			6'd18: u = mk(U_MOV, RG_RS, RG_P1, RG_K, 6'd19);
			6'd19: u = mk(U_EMIT, RG_K, RG_T1, RG_K, 6'd31);
			// two-sum of running sum and low product
			6'd20: u = mk(U_ADD, RG_S, RG_RS, RG_T1, 6'd21);
			6'd21: u = mk(U_SUB, RG_T0, RG_S, RG_RS, 6'd22);
			6'd22: u = mk(U_SUB, RG_AHI, RG_S, RG_T0, 6'd23);
			6'd23: u = mk(U_SUB, RG_ALO, RG_RS, RG_AHI, 6'd24);
			6'd24: u = mk(U_SUB, RG_T1, RG_T1, RG_T0, 6'd25);
			6'd25: u = mk(U_ADD, RG_T1, RG_ALO, RG_T1, 6'd26);
			6'd26: u = mk(U_EMIT, RG_K, RG_T1, RG_K, 6'd27);
			// fast two-sum with high product
			6'd27: u = mk(U_ADD, RG_RS, RG_P1, RG_S, 6'd28);
			6'd28: u = mk(U_SUB, RG_T0, RG_RS, RG_P1, 6'd29);
			6'd29: u = mk(U_SUB, RG_T0, RG_S, RG_T0, 6'd30);
			6'd30: u = mk(U_EMIT, RG_K, RG_T0, RG_K, 6'd31);
			6'd31: u = mk(U_FINAL, RG_K, RG_RS, RG_K, 6'd32);
			default: u = mk(U_END, RG_K, RG_K, RG_K, 6'd0);
		endcase
		return u;
	endfunction

endpackage

>>> sv/esze_fpu.sv
// shared binary64 add, subtract and multiply unit, multi-cycle
module esze_fpu (
	input logic clk,
	input logic arst_n,
	input esze_pkg::fpu_req_t req,
	input logic [63:0] a,
	input logic [63:0] b,
	output logic done,
	output logic [63:0] res
);

	typedef enum logic [2:0] {F_IDLE, F_ADD, F_MUL, F_NORM, F_ROUND} fstate_t;

	fstate_t state_q;
	logic [1:0] pp_q;
	logic done_q;
	logic [63:0] res_q;
	logic sa_q, sb_q, sign_q;
	logic [10:0] ea_q, eb_q;
	logic [52:0] ma_q, mb_q;
	logic [105:0] acc_q;
	logic signed [13:0] base_q, e_q;
	logic [63:0] m_q;
	logic st_q;

	function automatic logic [6:0] lzc106(input logic [105:0] v);
		logic [6:0] n;
		n = 7'd0;
		for (int i = 0; i < 106; i++) begin
			if (v[i]) n = 7'(105 - i);
		end
		return n;
	endfunction

	// operand decode and special values
	logic [10:0] ia_e, ib_e;
	logic [51:0] ia_f, ib_f;
	logic ib_s, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, spec;
	logic [63:0] spec_val;

	always_comb begin
		ia_e = a[62:52];
		ib_e = b[62:52];
		ia_f = a[51:0];
		ib_f = b[51:0];
		ib_s = b[63] ^ (req.op == esze_pkg::FOP_SUB);
		a_nan = (ia_e == 11'h7FF) && (ia_f != 52'd0);
		b_nan = (ib_e == 11'h7FF) && (ib_f != 52'd0);
		a_inf = (ia_e == 11'h7FF) && (ia_f == 52'd0);
		b_inf = (ib_e == 11'h7FF) && (ib_f == 52'd0);
		a_zero = a[62:0] == 63'd0;
		b_zero = b[62:0] == 63'd0;
		spec = 1'b1;
		spec_val = esze_pkg::DEFAULT_NAN;
		if (a_nan) begin
			spec_val = a | 64'h0008_0000_0000_0000;
		end else if (b_nan) begin
			spec_val = b | 64'h0008_0000_0000_0000;
		end else if (req.op == esze_pkg::FOP_MUL) begin
			if ((a_inf && b_zero) || (b_inf && a_zero)) begin
				spec_val = esze_pkg::DEFAULT_NAN;
			end else if (a_inf || b_inf) begin
				spec_val = {a[63] ^ b[63], 11'h7FF, 52'd0};
			end else if (a_zero || b_zero) begin
				spec_val = {a[63] ^ b[63], 63'd0};
			end else begin
				spec = 1'b0;
			end
		end else begin
			if (a_inf && b_inf && (a[63] != ib_s)) begin
				spec_val = esze_pkg::DEFAULT_NAN;
			end else if (a_inf) begin
				spec_val = a;
			end else if (b_inf) begin
				spec_val = {ib_s, b[62:0]};
			end else if (a_zero && b_zero) begin
				spec_val = {a[63] & ib_s, 63'd0};
			end else begin
				spec = 1'b0;
			end
		end
	end

	// alignment and add
	logic swap, bs;
	logic [52:0] bm, smm;
	logic [10:0] be, se, d;
	logic [55:0] ext, al_sh, aligned;
	logic al_st;
	logic [56:0] mag;

	always_comb begin
		swap = {ea_q, ma_q} < {eb_q, mb_q};
		bm = swap ? mb_q : ma_q;
		be = swap ? eb_q : ea_q;
		bs = swap ? sb_q : sa_q;
		smm = swap ? ma_q : mb_q;
		se = swap ? ea_q : eb_q;
		d = be - se;
		ext = {smm, 3'b000};
		if (d >= 11'd56) begin
			al_sh = 56'd0;
			al_st = |smm;
		end else begin
			al_sh = ext >> d[5:0];
			al_st = |(ext & ((56'd1 << d[5:0]) - 56'd1));
		end
		aligned = {al_sh[55:1], al_sh[0] | al_st};
		if (sa_q == sb_q) begin
			mag = {1'b0, bm, 3'b000} + {1'b0, aligned};
		end else begin
			mag = {1'b0, bm, 3'b000} - {1'b0, aligned};
		end
	end

	// one partial product per cycle
	logic [26:0] px, py;
	logic [53:0] prod;
	logic [6:0] psh;

	always_comb begin
		case (pp_q)
			2'd0: begin
				px = ma_q[26:0];
				py = mb_q[26:0];
				psh = 7'd0;
			end
			2'd1: begin
				px = ma_q[26:0];
				py = {1'b0, mb_q[52:27]};
				psh = 7'd27;
			end
			2'd2: begin
				px = {1'b0, ma_q[52:27]};
				py = mb_q[26:0];
				psh = 7'd27;
			end
			default: begin
				px = {1'b0, ma_q[52:27]};
				py = {1'b0, mb_q[52:27]};
				psh = 7'd54;
			end
		endcase
		prod = px * py;
	end

	// normalize
	logic [6:0] lz;
	logic [105:0] nshift;

	always_comb begin
		lz = lzc106(acc_q);
		nshift = acc_q << lz;
	end

	// round to nearest even and pack
	logic signed [13:0] ee, ef;
	logic [13:0] shamt;
	logic [63:0] ms;
	logic st2, inc;
	logic [53:0] r;
	logic [51:0] frac;
	logic [63:0] packed_res;

	always_comb begin
		if (e_q < 14'sd1) begin
			shamt = 14'(14'sd1 - e_q);
			ee = 14'sd1;
		end else begin
			shamt = 14'd0;
			ee = e_q;
		end
		if (shamt >= 14'd64) begin
			ms = 64'd0;
			st2 = (|m_q) | st_q;
		end else begin
			ms = m_q >> shamt[5:0];
			st2 = (|(m_q & ((64'd1 << shamt[5:0]) - 64'd1))) | st_q;
		end
		inc = ms[10] & ((|ms[9:0]) | st2 | ms[11]);
		r = {1'b0, ms[63:11]} + {53'd0, inc};
		if (r[53]) begin
			ef = ee + 14'sd1;
			frac = 52'd0;
		end else if (r[52]) begin
			ef = ee;
			frac = r[51:0];
		end else begin
			ef = 14'sd0;
			frac = r[51:0];
		end
		if (ef >= 14'sd2047) begin
			packed_res = {sign_q, 11'h7FF, 52'd0};
		end else begin
			packed_res = {sign_q, ef[10:0], frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pp_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						pp_q <= 2'd0;
						if (spec) begin
							done_q <= 1'b1;
						end else if (req.op == esze_pkg::FOP_MUL) begin
							state_q <= F_MUL;
						end else begin
							state_q <= F_ADD;
						end
					end
				end
				F_ADD: begin
					if (mag == 57'd0) begin
						done_q <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_NORM;
					end
				end
				F_MUL: begin
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3) state_q <= F_NORM;
				end
				F_NORM: state_q <= F_ROUND;
				F_ROUND: begin
					done_q <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					res_q <= spec_val;
					sa_q <= a[63];
					sb_q <= (req.op == esze_pkg::FOP_MUL) ? b[63] : ib_s;
					ea_q <= (ia_e == 11'd0) ? 11'd1 : ia_e;
					eb_q <= (ib_e == 11'd0) ? 11'd1 : ib_e;
					ma_q <= {ia_e != 11'd0, ia_f};
					mb_q <= {ib_e != 11'd0, ib_f};
					acc_q <= 106'd0;
				end
			end
			F_ADD: begin
				res_q <= 64'd0;
				acc_q <= {mag, 49'd0};
				base_q <= 14'(be) + 14'sd1;
				sign_q <= bs;
			end
			F_MUL: begin
				acc_q <= acc_q + ({52'd0, prod} << psh);
				base_q <= 14'(ea_q) + 14'(eb_q) - 14'sd1022;
				sign_q <= sa_q ^ sb_q;
			end
			F_NORM: begin
				m_q <= nshift[105:42];
				st_q <= |nshift[41:0];
				e_q <= base_q - 14'(lz);
			end
			F_ROUND: res_q <= packed_res;
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

>>> sv/esze_ctrl.sv
// microcode sequencer with operand registers and result holding stage
`include "expansion_scale_zero_elim_defines.svh"

module esze_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] component_bits,
	input logic [63:0] scale_bits,
	input logic last_component,
	input logic out_free,
	output esze_pkg::push_t push,
	output esze_pkg::fpu_req_t fpu_req,
	output logic [63:0] fpu_a,
	output logic [63:0] fpu_b,
	input logic fpu_done,
	input logic [63:0] fpu_res
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

	state_t state_q;
	logic [esze_pkg::PC_W-1:0] pc_q;
	logic first_q, last_q, inside_q, emitted_q, pend_vld_q, pend_fin_q;
	logic [63:0] pend_bits_q;
	logic [63:0] comp_q, sv_q, sh_q, sl_q, rs_q, p1_q, ahi_q, alo_q, s_q, t0_q, t1_q;

	esze_pkg::uinst_t inst;
	logic [63:0] va, vb, wr_val;
	logic nz_a, blocked, put_req, put_go, end_go, wr_en, accept;

	always_comb begin
		inst = esze_pkg::ucode(pc_q);
		unique case (inst.a)
			esze_pkg::RG_K: va = esze_pkg::SPLITTER;
			esze_pkg::RG_COMP: va = comp_q;
			esze_pkg::RG_SV: va = sv_q;
			esze_pkg::RG_SH: va = sh_q;
			esze_pkg::RG_SL: va = sl_q;
			esze_pkg::RG_RS: va = rs_q;
			esze_pkg::RG_P1: va = p1_q;
			esze_pkg::RG_AHI: va = ahi_q;
			esze_pkg::RG_ALO: va = alo_q;
			esze_pkg::RG_S: va = s_q;
			esze_pkg::RG_T0: va = t0_q;
			default: va = t1_q;
		endcase
		unique case (inst.b)
			esze_pkg::RG_K: vb = esze_pkg::SPLITTER;
			esze_pkg::RG_COMP: vb = comp_q;
			esze_pkg::RG_SV: vb = sv_q;
			esze_pkg::RG_SH: vb = sh_q;
			esze_pkg::RG_SL: vb = sl_q;
			esze_pkg::RG_RS: vb = rs_q;
			esze_pkg::RG_P1: vb = p1_q;
			esze_pkg::RG_AHI: vb = ahi_q;
			esze_pkg::RG_ALO: vb = alo_q;
			esze_pkg::RG_S: vb = s_q;
			esze_pkg::RG_T0: vb = t0_q;
			default: vb = t1_q;
		endcase
		nz_a = |va[62:0];
		blocked = pend_vld_q && !out_free;
		put_req = (state_q == S_RUN) && (((inst.op == esze_pkg::U_EMIT) && nz_a) ||
			((inst.op == esze_pkg::U_FINAL) && last_q && (nz_a || !emitted_q)));
		put_go = put_req && !blocked;
		end_go = (state_q == S_RUN) && (inst.op == esze_pkg::U_END) && !blocked;
		accept = (state_q == S_IDLE) && in_valid;
		wr_en = ((state_q == S_RUN) && (inst.op == esze_pkg::U_MOV)) ||
			((state_q == S_WAIT) && fpu_done);
		wr_val = (state_q == S_WAIT) ? fpu_res : va;
	end

	always_comb begin
		fpu_req.start = (state_q == S_RUN) && ((inst.op == esze_pkg::U_ADD) ||
			(inst.op == esze_pkg::U_SUB) || (inst.op == esze_pkg::U_MUL));
		unique case (inst.op)
			esze_pkg::U_SUB: fpu_req.op = esze_pkg::FOP_SUB;
			esze_pkg::U_MUL: fpu_req.op = esze_pkg::FOP_MUL;
			default: fpu_req.op = esze_pkg::FOP_ADD;
		endcase
		push.vld = (put_go || end_go) && pend_vld_q;
		push.bits = pend_bits_q;
		push.eor = end_go;
		push.eoe = pend_fin_q;
	end

	assign fpu_a = va;
	assign fpu_b = vb;
	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= esze_pkg::PC_START;
			first_q <= 1'b0;
			last_q <= 1'b0;
			inside_q <= 1'b0;
			emitted_q <= 1'b0;
			pend_vld_q <= 1'b0;
			pend_fin_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						pc_q <= inside_q ? esze_pkg::PC_PROD : esze_pkg::PC_START;
						first_q <= !inside_q;
						last_q <= last_component;
						if (!inside_q) emitted_q <= 1'b0;
					end
				end
				S_RUN: begin
					unique case (inst.op) inside
						esze_pkg::U_ADD, esze_pkg::U_SUB, esze_pkg::U_MUL: state_q <= S_WAIT;
						esze_pkg::U_MOV: pc_q <= inst.nxt;
						esze_pkg::U_BRANCH: pc_q <= first_q ? pc_q + 6'd1 : inst.nxt;
						esze_pkg::U_EMIT, esze_pkg::U_FINAL: begin
							if (!put_req) begin
								pc_q <= inst.nxt;
							end else if (put_go) begin
								pc_q <= inst.nxt;
								pend_vld_q <= 1'b1;
								pend_fin_q <= inst.op == esze_pkg::U_FINAL;
								emitted_q <= 1'b1;
							end
						end
						default: begin
							if (end_go) begin
								pend_vld_q <= 1'b0;
								inside_q <= !last_q;
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_WAIT: begin
					if (fpu_done) begin
						pc_q <= inst.nxt;
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			comp_q <= component_bits;
			if (!inside_q) sv_q <= scale_bits;
		end
		if (put_go) pend_bits_q <= va;
		if (wr_en) begin
			case (inst.dst)
				esze_pkg::RG_SH: sh_q <= wr_val;
				esze_pkg::RG_SL: sl_q <= wr_val;
				esze_pkg::RG_RS: rs_q <= wr_val;
				esze_pkg::RG_P1: p1_q <= wr_val;
				esze_pkg::RG_AHI: ahi_q <= wr_val;
				esze_pkg::RG_ALO: alo_q <= wr_val;
				esze_pkg::RG_S: s_q <= wr_val;
				esze_pkg::RG_T0: t0_q <= wr_val;
				esze_pkg::RG_T1: t1_q <= wr_val;
				default: ;
			endcase
		end
	end

	`ESZE_ASSERT_IMPL(a_done_in_wait, fpu_done, state_q == S_WAIT, "fpu result with nothing pending")
	`ESZE_ASSERT_IMPL(a_idle_no_pend, state_q == S_IDLE, !pend_vld_q, "held result left in idle")
	`ESZE_ASSERT_IMPL(a_eoe_is_eor, push.vld && push.eoe, push.eor, "final sum not last of item")
	`ESZE_ASSERT_NEXT(a_first_starts_split, accept && !inside_q, pc_q == esze_pkg::PC_START, "bad entry point")

endmodule

>>> sv/expansion_scale_zero_elim.sv
// in_stall stays high from a component transaction until its microcode has ended
// the microcoded ops run one at a time on one shared fpu; special operands skip its steps
// fpu: add/sub align and add (a zero sum ends there), mul sums partial products, then normalize
// throughput: one component at a time, longer while a finished result waits on out_stall
// a finished result waits in the output register while the next component runs
// reset: asynchronous active low, clears sequencer, fpu control and output valid
module expansion_scale_zero_elim (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] component_bits,
	input logic [63:0] scale_bits,
	input logic last_component,
	output logic out_valid,
	input logic out_stall,
	output logic [63:0] result_bits,
	output logic end_of_run,
	output logic end_of_expansion
);

	esze_pkg::push_t push;
	esze_pkg::fpu_req_t fpu_req;
	logic [63:0] fpu_a, fpu_b, fpu_res;
	logic fpu_done, out_free;
	logic out_vld_q, eor_q, eoe_q;
	logic [63:0] bits_q;

	assign out_free = !out_vld_q || !out_stall;

	esze_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.component_bits(component_bits),
		.scale_bits(scale_bits),
		.last_component(last_component),
		.out_free(out_free),
		.push(push),
		.fpu_req(fpu_req),
		.fpu_a(fpu_a),
		.fpu_b(fpu_b),
		.fpu_done(fpu_done),
		.fpu_res(fpu_res)
	);

	esze_fpu u_fpu (
		.clk(clk),
		.arst_n(arst_n),
		.req(fpu_req),
		.a(fpu_a),
		.b(fpu_b),
		.done(fpu_done),
		.res(fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.vld) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			bits_q <= push.bits;
			eor_q <= push.eor;
			eoe_q <= push.eoe;
		end
	end

	assign out_valid = out_vld_q;
	assign result_bits = bits_q;
	assign end_of_run = eor_q;
	assign end_of_expansion = eoe_q;

endmodule

>>> bench/expansion_scale_zero_elim_tb.sv
// testbench for the expansion scaler: random and directed expansions against a binary64 predictor
`timescale 1ns / 1ps

module expansion_scale_zero_elim_tb;

	typedef struct {
		logic [63:0] comp;
		logic [63:0] scale;
		logic last;
		bit drain;
	} comp_item_t;

	typedef struct {
		logic [63:0] bits;
		logic eor;
		logic eoe;
	} scaled_part_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [63:0] component_bits = '0;
	logic [63:0] scale_bits = '0;
	logic last_component = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] result_bits;
	logic end_of_run;
	logic end_of_expansion;

	comp_item_t pending_q[$];
	scaled_part_t scaled_q[$];
	int sent = 0;
	int received = 0;
	int expansions = 0;
	int errors = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit hold_done = 0;
	bit took = 0;

	real sum_r, sv_r, sh_r, sl_r;
	bit in_exp = 0;
	bit emitted = 0;

	expansion_scale_zero_elim dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.component_bits(component_bits), .scale_bits(scale_bits),
		.last_component(last_component),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_bits(result_bits), .end_of_run(end_of_run),
		.end_of_expansion(end_of_expansion)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic logic [63:0] fp(input bit s, input int e, input logic [51:0] m);
		return {s, e[10:0], m};
	endfunction

	task automatic veltkamp(input real a, output real hi, output real lo);
		real c, big;
		c = 134217729.0 * a;
		big = c - a;
		hi = c - big;
		lo = a - hi;
	endtask

	task automatic two_product(input real a, output real x, output real y);
		real ahi, alo, e1, e2, e3, t;
		x = a * sv_r;
		veltkamp(a, ahi, alo);
		t = ahi * sh_r;
		e1 = x - t;
		t = alo * sh_r;
		e2 = e1 - t;
		t = ahi * sl_r;
		e3 = e2 - t;
		t = alo * sl_r;
		y = t - e3;
	endtask

	task automatic push_part(input real v, input bit fin);
		scaled_part_t p;
		p.bits = $realtobits(v);
		p.eor = 0;
		p.eoe = fin;
		scaled_q.push_back(p);
		emitted = 1;
	endtask

	task automatic predict_scale(input comp_item_t it);
		real c, p1, p0, s, hh, bv, av, t1, t2;
		int n0;
		n0 = scaled_q.size();
		c = $bitstoreal(it.comp);
		if (!in_exp) begin
			sv_r = $bitstoreal(it.scale);
			veltkamp(sv_r, sh_r, sl_r);
			emitted = 0;
			two_product(c, p1, hh);
			sum_r = p1;
			if (hh != 0.0) push_part(hh, 0);
		end else begin
			two_product(c, p1, p0);
			s = sum_r + p0;
			bv = s - sum_r;
			av = s - bv;
			t1 = sum_r - av;
			t2 = p0 - bv;
			hh = t1 + t2;
			if (hh != 0.0) push_part(hh, 0);
			sum_r = p1 + s;
			t1 = sum_r - p1;
			hh = s - t1;
			if (hh != 0.0) push_part(hh, 0);
		end
		if (it.last) begin
			if (sum_r != 0.0 || !emitted) push_part(sum_r, 1);
			in_exp = 0;
			expansions++;
		end else begin
			in_exp = 1;
		end
		if (scaled_q.size() > n0) scaled_q[scaled_q.size()-1].eor = 1;
	endtask

	function automatic int send_idle_pct();
		if (sent < 60) return 17;
		if (sent < 100) return 58;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (sent < 60) return 58;
		if (sent < 100) return 17;
		return 0;
	endfunction

	// sender
	always @(posedge clk) begin
		took <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			comp_item_t it;
			it.comp = component_bits;
			it.scale = scale_bits;
			it.last = last_component;
			it.drain = 0;
			predict_scale(it);
			sent++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			if (pending_q.size() > 0 && pending_q[0].drain) begin
				in_valid <= 0;
				if (scaled_q.size() == 0) void'(pending_q.pop_front());
			end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
				comp_item_t it;
				it = pending_q.pop_front();
				in_valid <= 1;
				component_bits <= it.comp;
				scale_bits <= it.scale;
				last_component <= it.last;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!hold_done && sent == 30) begin
			hold_done <= 1;
			hold_left <= 400;
			out_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct());
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			received++;
			if (scaled_q.size() == 0) begin
				$display("%0t: unexpected transaction expected none actual %h eor %b eoe %b",
					$time, result_bits, end_of_run, end_of_expansion);
				errors++;
			end else begin
				scaled_part_t e;
				e = scaled_q.pop_front();
				if (result_bits !== e.bits && !(e.bits[62:52] == 11'h7FF && e.bits[51:0] != 0
						&& result_bits[62:52] == 11'h7FF && result_bits[51:0] != 0)) begin
					$display("%0t: result_bits expected %h actual %h", $time, e.bits, result_bits);
					errors++;
				end
				if (end_of_run !== e.eor) begin
					$display("%0t: end_of_run expected %b actual %b", $time, e.eor, end_of_run);
					errors++;
				end
				if (end_of_expansion !== e.eoe) begin
					$display("%0t: end_of_expansion expected %b actual %b",
						$time, e.eoe, end_of_expansion);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 8000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_comp(input logic [63:0] c, input logic [63:0] s, input bit l);
		comp_item_t it;
		it.comp = c;
		it.scale = s;
		it.last = l;
		it.drain = 0;
		pending_q.push_back(it);
	endtask

	task automatic add_drain();
		comp_item_t it;
		it.comp = 0;
		it.scale = 0;
		it.last = 0;
		it.drain = 1;
		pending_q.push_back(it);
	endtask

	function automatic logic [63:0] rand_bits();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_scale();
		int k;
		k = $urandom_range(9);
		if (k == 0) return rand_bits();
		if (k == 1) return fp(1'($urandom_range(1)), 1023, 52'd0);
		return fp(1'($urandom_range(1)), $urandom_range(700, 1340),
			52'({$urandom(), $urandom()}));
	endfunction

	initial begin
		int len, e;
		logic [63:0] s, c, prev;
		// directed
		add_comp(64'h0, fp(0, 1024, 0), 1);
		add_comp(64'h8000_0000_0000_0000, fp(1, 1024, 0), 1);
		add_comp(fp(0, 1023, 1), fp(0, 1023, 1), 1);
		add_comp(fp(0, 1023, 0), fp(0, 1024, 52'h8_0000_0000_0000), 0);
		add_comp(fp(0, 1083, 0), fp(0, 1023, 0), 0);
		add_comp(fp(1, 1083, 0), fp(0, 1023, 0), 1);
		add_comp(fp(0, 1023, 1), fp(0, 1023, 1), 0);
		add_comp(fp(1, 1023, 2), 64'h0, 1);
		add_comp(64'h7FEF_FFFF_FFFF_FFFF, fp(0, 1024, 0), 1);
		add_comp(64'h0000_0000_0000_0001, fp(0, 1022, 0), 1);
		add_comp(64'h7FF0_0000_0000_0000, fp(0, 1023, 0), 1);
		add_comp(64'hFFF8_0000_0000_0001, fp(0, 1023, 0), 1);
		add_comp(fp(0, 1023, 3), 64'h7FEF_FFFF_FFFF_FFFF, 1);
		add_comp(fp(0, 1023, 0), 64'h0, 1);
		add_comp(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1);
		add_comp(64'h0, 64'h0, 0);
		add_comp(fp(1, 1100, 52'hF_FFFF_FFFF_FFFF), 64'h8000_0000_0000_0000, 1);
		add_drain();
		// random expansions
		while (pending_q.size() < 132) begin
			len = $urandom_range(1, 4);
			s = rand_scale();
			e = $urandom_range(600, 1000);
			prev = 0;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) c = rand_bits();
				else if (i > 0 && $urandom_range(5) == 0) c = prev ^ 64'h8000_0000_0000_0000;
				else c = fp(1'($urandom_range(1)), e, 52'({$urandom(), $urandom()}));
				e = e + $urandom_range(53, 70);
				prev = c;
				add_comp(c, s, i == len - 1);
			end
			if ($urandom_range(15) == 0) add_drain();
		end
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_q.size() == 0 && !in_valid);
		wait (scaled_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("covered %0d components in %0d expansions, %0d results returned",
			sent, expansions, received);
		if (errors == 0 && scaled_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
